@@ src/bra_pkg.sv @@
// ----------------------------------------------------------------------------
// bra_pkg: shared types and codes of the banker's resource allocator
// Holds the controller state type, the opcode and result codes, and the
// command and status bundles exchanged between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bra_pkg;

  // input opcodes
  localparam logic [2:0] OP_SET_MAX   = 3'd0;
  localparam logic [2:0] OP_SET_ALLOC = 3'd1;
  localparam logic [2:0] OP_SET_AVAIL = 3'd2;
  localparam logic [2:0] OP_REQUEST   = 3'd3;
  localparam logic [2:0] OP_CHECK     = 3'd4;

  // result status codes
  localparam logic [2:0] ST_STORED      = 3'd0;
  localparam logic [2:0] ST_BAD_ENTRY   = 3'd1;
  localparam logic [2:0] ST_GRANTED     = 3'd2;
  localparam logic [2:0] ST_DENIED      = 3'd3;
  localparam logic [2:0] ST_OVER_NEED   = 3'd4;
  localparam logic [2:0] ST_OVER_AVAIL  = 3'd5;
  localparam logic [2:0] ST_SAFE        = 3'd6;
  localparam logic [2:0] ST_UNSAFE      = 3'd7;

  // configuration register indexes
  localparam logic CFG_ACTIVE_PROCESSES = 1'b0;
  localparam logic CFG_ACTIVE_RESOURCES = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_LOAD_WR,
    S_REQ_CHK,
    S_SCAN_INIT,
    S_SCAN_RD,
    S_SCAN_EV,
    S_FIX_RD,
    S_FIX,
    S_REL_RD,
    S_REL,
    S_EMIT_ONE,
    S_EMIT_SEQ
  } ctl_state_t;

  typedef struct packed {
    logic       latch;
    logic       addr_scan;
    logic       set_status;
    logic [2:0] status;
    logic       wr_max;
    logic       wr_alloc;
    logic       wr_avail;
    logic       wr_req;
    logic       apply;
    logic       scan_init;
    logic       scan_eval;
    logic       rollback;
    logic       rel_row;
    logic       emit_one;
    logic       emit_seq;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       last_elem;
    logic       p_ok;
    logic       r_ok;
    logic       over_max;
    logic       over_need;
    logic       over_avail;
    logic       scan_safe;
    logic       scan_stuck;
    logic       safe;
    logic       seq_last;
    logic       out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ src/bra_ctrl.sv @@
// ----------------------------------------------------------------------------
// bra_ctrl: sequencing controller
// Steps each accepted word through load, request decision, safety scan,
// rollback, release and result emission by issuing datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module bra_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire bra_pkg::dp_sts_t sts,
  output bra_pkg::dp_cmd_t      cmd
);

  bra_pkg::ctl_state_t state_r, state_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bra_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      bra_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = bra_pkg::S_DISPATCH;
        end
      end
      bra_pkg::S_DISPATCH: begin
        cmd.set_status = 1'b1;
        cmd.status     = bra_pkg::ST_BAD_ENTRY;
        state_nxt      = bra_pkg::S_EMIT_ONE;
        unique case (sts.op) inside
          bra_pkg::OP_SET_MAX, bra_pkg::OP_SET_ALLOC: begin
            cmd.set_status = 1'b0;
            state_nxt      = bra_pkg::S_LOAD_WR;
          end
          bra_pkg::OP_SET_AVAIL: begin
            if (sts.r_ok) begin
              cmd.wr_avail = 1'b1;
              cmd.status   = bra_pkg::ST_STORED;
            end
          end
          bra_pkg::OP_REQUEST: begin
            cmd.wr_req = sts.r_ok;
            if (!sts.last_elem) begin
              cmd.status = sts.r_ok ? bra_pkg::ST_STORED : bra_pkg::ST_BAD_ENTRY;
            end else if (sts.p_ok) begin
              cmd.set_status = 1'b0;
              state_nxt      = bra_pkg::S_REQ_CHK;
            end
          end
          bra_pkg::OP_CHECK: begin
            cmd.set_status = 1'b0;
            state_nxt      = bra_pkg::S_SCAN_INIT;
          end
          default: begin
            cmd.status = bra_pkg::ST_BAD_ENTRY;
          end
        endcase
      end
      bra_pkg::S_LOAD_WR: begin
        cmd.set_status = 1'b1;
        cmd.status     = bra_pkg::ST_BAD_ENTRY;
        if (sts.p_ok && sts.r_ok) begin
          if (sts.op == bra_pkg::OP_SET_MAX) begin
            cmd.wr_max = 1'b1;
            cmd.status = bra_pkg::ST_STORED;
          end else if (!sts.over_max) begin
            cmd.wr_alloc = 1'b1;
            cmd.status   = bra_pkg::ST_STORED;
          end
        end
        state_nxt = bra_pkg::S_EMIT_ONE;
      end
      bra_pkg::S_REQ_CHK: begin
        if (sts.over_need) begin
          cmd.set_status = 1'b1;
          cmd.status     = bra_pkg::ST_OVER_NEED;
          state_nxt      = bra_pkg::S_EMIT_ONE;
        end else if (sts.over_avail) begin
          cmd.set_status = 1'b1;
          cmd.status     = bra_pkg::ST_OVER_AVAIL;
          state_nxt      = bra_pkg::S_EMIT_ONE;
        end else begin
          cmd.apply = 1'b1;
          state_nxt = bra_pkg::S_SCAN_INIT;
        end
      end
      bra_pkg::S_SCAN_INIT: begin
        cmd.scan_init = 1'b1;
        state_nxt     = bra_pkg::S_SCAN_RD;
      end
      bra_pkg::S_SCAN_RD: begin
        cmd.addr_scan = 1'b1;
        state_nxt     = bra_pkg::S_SCAN_EV;
      end
      bra_pkg::S_SCAN_EV: begin
        cmd.scan_eval = 1'b1;
        if (sts.scan_safe || sts.scan_stuck) begin
          if (sts.op == bra_pkg::OP_CHECK) begin
            cmd.set_status = 1'b1;
            cmd.status     = sts.scan_safe ? bra_pkg::ST_SAFE : bra_pkg::ST_UNSAFE;
            state_nxt      = sts.scan_safe ? bra_pkg::S_EMIT_SEQ : bra_pkg::S_EMIT_ONE;
          end else begin
            state_nxt = bra_pkg::S_FIX_RD;
          end
        end else begin
          state_nxt = bra_pkg::S_SCAN_RD;
        end
      end
      bra_pkg::S_FIX_RD: begin
        state_nxt = bra_pkg::S_FIX;
      end
      bra_pkg::S_FIX: begin
        cmd.rollback = 1'b1;
        state_nxt    = bra_pkg::S_REL_RD;
      end
      bra_pkg::S_REL_RD: begin
        state_nxt = bra_pkg::S_REL;
      end
      bra_pkg::S_REL: begin
        cmd.rel_row    = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status     = sts.safe ? bra_pkg::ST_GRANTED : bra_pkg::ST_DENIED;
        state_nxt      = sts.safe ? bra_pkg::S_EMIT_SEQ : bra_pkg::S_EMIT_ONE;
      end
      bra_pkg::S_EMIT_ONE: begin
        cmd.emit_one = 1'b1;
        if (sts.out_free) begin
          state_nxt = bra_pkg::S_IDLE;
        end
      end
      bra_pkg::S_EMIT_SEQ: begin
        cmd.emit_seq = 1'b1;
        if (sts.out_free && sts.seq_last) begin
          state_nxt = bra_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bra_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/bra_datapath.sv @@
// ----------------------------------------------------------------------------
// bra_datapath: allocation tables, scan registers and result register
// Keeps the claim, allocation and need tables as row memories (one row per
// process), the available, request and work vectors, and the output word.
// ----------------------------------------------------------------------------
`default_nettype none

module bra_datapath #(
  parameter int PROCESSES   = 16,
  parameter int RESOURCES   = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bra_pkg::dp_cmd_t cmd,
  output bra_pkg::dp_sts_t      sts,
  input  wire logic [2:0]       in_opcode,
  input  wire logic [3:0]       in_process_index,
  input  wire logic [2:0]       in_resource_index,
  input  wire logic [15:0]      in_amount,
  input  wire logic             in_last_element,
  input  wire logic             cfg_valid,
  input  wire logic             cfg_index,
  input  wire logic [4:0]       cfg_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [2:0]            out_status,
  output logic                  out_released,
  output logic                  out_sequence_valid,
  output logic [3:0]            out_sequence_process,
  output logic                  out_last
);

  localparam int PIW  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int RIW  = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int CNTW = $clog2(PROCESSES + 1);
  localparam int NRW  = $clog2(RESOURCES + 1);
  localparam int CW   = COUNT_WIDTH;

  typedef logic [RESOURCES-1:0][CW-1:0] row_t;

  // configuration
  logic [4:0]      ap_r;
  logic [3:0]      ar_r;
  logic [CNTW-1:0] np;
  logic [NRW-1:0]  nr;

  // latched word
  logic [2:0]    it_op_r;
  logic [3:0]    it_p_r;
  logic [2:0]    it_r_r;
  logic [CW-1:0] it_amt_r;
  logic          it_last_r;

  // tables
  row_t                 mem_max   [PROCESSES];
  row_t                 mem_alloc [PROCESSES];
  row_t                 mem_need  [PROCESSES];
  logic [PROCESSES-1:0] row_vld_r;
  row_t                 rd_max_raw_r, rd_alloc_raw_r, rd_need_raw_r;
  logic                 rd_vld_r;
  row_t                 rmax, ralloc, rneed;
  row_t                 wmax, walloc, wneed;
  logic                 wr_en;
  logic [PIW-1:0]       p_addr, rd_addr;

  // vectors
  row_t avail_r, avail_nxt;
  row_t req_r;
  row_t work_r;

  // scan
  logic [PROCESSES-1:0] fin_r;
  logic [PROCESSES-1:0][PIW-1:0] order_r;
  logic [CNTW-1:0] count_r;
  logic [PIW-1:0]  pi_r;
  logic            prog_r;
  logic            safe_r;
  logic            fits;
  logic            pass_end;
  logic            done_safe;
  logic [CNTW-1:0] count_nxt;

  // decisions
  logic            p_ok, r_ok, rel_hit, over_need, over_avail, over_max;
  logic [RIW-1:0]  ri;

  // result
  logic [PIW-1:0] k_r;
  logic [2:0]     status_r;
  logic           rel_r;
  logic           seq_last;
  logic           out_free;
  logic           out_valid_r;
  logic [2:0]     out_status_r;
  logic           out_rel_r;
  logic           out_seqv_r;
  logic [3:0]     out_proc_r;
  logic           out_last_r;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  // clamp active counts
  always_comb begin
    if (ap_r == 5'd0) begin
      np = CNTW'(1);
    end else if (32'(ap_r) > 32'(PROCESSES)) begin
      np = CNTW'(PROCESSES);
    end else begin
      np = CNTW'(ap_r);
    end
    if (ar_r == 4'd0) begin
      nr = NRW'(1);
    end else if (32'(ar_r) > 32'(RESOURCES)) begin
      nr = NRW'(RESOURCES);
    end else begin
      nr = NRW'(ar_r);
    end
  end

  // write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ap_r <= 5'd1;
      ar_r <= 4'd1;
    end else if (cfg_valid) begin
      if (cfg_index == bra_pkg::CFG_ACTIVE_PROCESSES) begin
        ap_r <= cfg_data;
      end else begin
        ar_r <= cfg_data[3:0];
      end
    end
  end

  // latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      it_op_r   <= in_opcode;
      it_p_r    <= in_process_index;
      it_r_r    <= in_resource_index;
      it_amt_r  <= CW'(in_amount);
      it_last_r <= in_last_element;
    end
  end

  assign p_ok    = 32'(it_p_r) < 32'(np);
  assign r_ok    = 32'(it_r_r) < 32'(nr);
  assign ri      = RIW'(it_r_r);
  assign p_addr  = PIW'(it_p_r);
  assign rd_addr = cmd.addr_scan ? pi_r : p_addr;

  // read row, registered
  always_ff @(posedge clk) begin
    rd_max_raw_r   <= mem_max[rd_addr];
    rd_alloc_raw_r <= mem_alloc[rd_addr];
    rd_need_raw_r  <= mem_need[rd_addr];
  end

  // write row
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_max[p_addr]   <= wmax;
      mem_alloc[p_addr] <= walloc;
      mem_need[p_addr]  <= wneed;
    end
  end

  // track written rows; unwritten rows read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      rd_vld_r <= row_vld_r[rd_addr];
      if (wr_en) begin
        row_vld_r[p_addr] <= 1'b1;
      end
    end
  end

  assign rmax   = rd_vld_r ? rd_max_raw_r   : '0;
  assign ralloc = rd_vld_r ? rd_alloc_raw_r : '0;
  assign rneed  = rd_vld_r ? rd_need_raw_r  : '0;

  assign over_max = it_amt_r > rmax[ri];

  // find the first refused element, lowest resource first
  always_comb begin
    over_need  = 1'b0;
    over_avail = 1'b0;
    rel_hit    = 1'b1;
    for (int j = RESOURCES - 1; j >= 0; j--) begin
      if (32'(j) < 32'(nr)) begin
        if (req_r[j] > rneed[j]) begin
          over_need  = 1'b1;
          over_avail = 1'b0;
        end else if (req_r[j] > avail_r[j]) begin
          over_need  = 1'b0;
          over_avail = 1'b1;
        end
        if (rneed[j] != '0) begin
          rel_hit = 1'b0;
        end
      end
    end
  end

  // build the row and available vector to write back
  always_comb begin
    wmax      = rmax;
    walloc    = ralloc;
    wneed     = rneed;
    wr_en     = 1'b0;
    avail_nxt = avail_r;
    if (cmd.wr_max) begin
      wmax[ri] = it_amt_r;
      wr_en    = 1'b1;
    end
    if (cmd.wr_alloc) begin
      walloc[ri] = it_amt_r;
      wneed[ri]  = rmax[ri] - it_amt_r;
      wr_en      = 1'b1;
    end
    if (cmd.wr_avail) begin
      avail_nxt[ri] = it_amt_r;
    end
    if (cmd.apply) begin
      wr_en = 1'b1;
      for (int j = 0; j < RESOURCES; j++) begin
        if (32'(j) < 32'(nr)) begin
          walloc[j]    = ralloc[j] + req_r[j];
          wneed[j]     = rneed[j] - req_r[j];
          avail_nxt[j] = avail_r[j] - req_r[j];
        end
      end
    end
    if (cmd.rollback && !safe_r) begin
      wr_en = 1'b1;
      for (int j = 0; j < RESOURCES; j++) begin
        if (32'(j) < 32'(nr)) begin
          walloc[j]    = ralloc[j] - req_r[j];
          wneed[j]     = rneed[j] + req_r[j];
          avail_nxt[j] = avail_r[j] + req_r[j];
        end
      end
    end
    if (cmd.rel_row && rel_hit) begin
      wr_en = 1'b1;
      for (int j = 0; j < RESOURCES; j++) begin
        if (32'(j) < 32'(nr)) begin
          walloc[j]    = '0;
          wneed[j]     = '0;
          avail_nxt[j] = sat_add(avail_r[j], ralloc[j]);
        end
      end
    end
  end

  // hold available counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avail_r <= '0;
    end else begin
      avail_r <= avail_nxt;
    end
  end

  // store request elements
  always_ff @(posedge clk) begin
    if (cmd.wr_req) begin
      req_r[ri] <= it_amt_r;
    end
  end

  // evaluate one row of the safety scan
  always_comb begin
    fits = !fin_r[pi_r];
    for (int j = 0; j < RESOURCES; j++) begin
      if ((32'(j) < 32'(nr)) && (rneed[j] > work_r[j])) begin
        fits = 1'b0;
      end
    end
    count_nxt = count_r + CNTW'(fits);
    pass_end  = 32'(pi_r) == (32'(np) - 32'd1);
    done_safe = count_nxt == np;
  end

  // advance the scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r   <= '0;
      count_r <= '0;
      pi_r    <= '0;
      prog_r  <= 1'b0;
      safe_r  <= 1'b0;
    end else if (cmd.scan_init) begin
      fin_r   <= '0;
      count_r <= '0;
      pi_r    <= '0;
      prog_r  <= 1'b0;
      safe_r  <= 1'b0;
    end else if (cmd.scan_eval) begin
      count_r <= count_nxt;
      safe_r  <= done_safe;
      if (fits) begin
        fin_r[pi_r] <= 1'b1;
      end
      if (pass_end) begin
        pi_r   <= '0;
        prog_r <= 1'b0;
      end else begin
        pi_r   <= pi_r + PIW'(1);
        prog_r <= prog_r | fits;
      end
    end
  end

  // work vector and safe order
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      work_r <= avail_r;
    end else if (cmd.scan_eval && fits) begin
      for (int j = 0; j < RESOURCES; j++) begin
        if (32'(j) < 32'(nr)) begin
          work_r[j] <= sat_add(work_r[j], ralloc[j]);
        end
      end
      order_r[PIW'(count_r)] <= pi_r;
    end
  end

  // status and release flag of the current word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= bra_pkg::ST_STORED;
      rel_r    <= 1'b0;
    end else begin
      if (cmd.latch) begin
        rel_r <= 1'b0;
      end else if (cmd.rel_row) begin
        rel_r <= rel_hit;
      end
      if (cmd.set_status) begin
        status_r <= cmd.status;
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign seq_last = 32'(k_r) == (32'(np) - 32'd1);

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      if (cmd.latch) begin
        k_r <= '0;
      end
      if ((cmd.emit_one || cmd.emit_seq) && out_free) begin
        out_valid_r <= 1'b1;
        if (cmd.emit_seq) begin
          k_r <= k_r + PIW'(1);
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.emit_one || cmd.emit_seq) && out_free) begin
      out_status_r <= status_r;
      out_rel_r    <= rel_r;
      out_seqv_r   <= cmd.emit_seq;
      out_proc_r   <= cmd.emit_seq ? 4'(order_r[k_r]) : 4'd0;
      out_last_r   <= cmd.emit_seq ? seq_last : 1'b1;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_released         = out_rel_r;
  assign out_sequence_valid   = out_seqv_r;
  assign out_sequence_process = out_proc_r;
  assign out_last             = out_last_r;

  always_comb begin
    sts.op         = it_op_r;
    sts.last_elem  = it_last_r;
    sts.p_ok       = p_ok;
    sts.r_ok       = r_ok;
    sts.over_max   = over_max;
    sts.over_need  = over_need;
    sts.over_avail = over_avail;
    sts.scan_safe  = done_safe;
    sts.scan_stuck = pass_end && !(prog_r || fits) && !done_safe;
    sts.safe       = safe_r;
    sts.seq_last   = seq_last;
    sts.out_free   = out_free;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_eval |-> count_r < np)
    else $error("scan count exceeds active processes");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_seqv_r |-> out_last_r)
    else $error("single result without last");

  a_seq_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_seqv_r |->
      (out_status_r == bra_pkg::ST_GRANTED) || (out_status_r == bra_pkg::ST_SAFE))
    else $error("sequence entry with wrong status");

  a_rel_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rel_r |->
      (out_status_r == bra_pkg::ST_GRANTED) || (out_status_r == bra_pkg::ST_DENIED))
    else $error("release flagged on a non-decision result");
`endif

endmodule

`default_nettype wire

@@ src/bankers_resource_allocator.sv @@
// ----------------------------------------------------------------------------
// bankers_resource_allocator: deadlock-avoiding resource allocator
// Loads claim, allocation and available tables, decides requests with a
// safety scan and reports the safe sequence.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_*) are taken when in_valid is high and in_stall low; the
//   block takes one word at a time and raises in_stall until the word's last
//   result has entered the output register. Result words (out_*) leave when
//   out_valid is high and out_stall low; out_last marks a word's final result.
//   Configuration (cfg_*) is always ready; it is to be written only while idle,
//   which the block itself does not enforce. The safety scan reads one
//   process row from the row memory and then evaluates it, pass after pass
//   over the N active processes (passes <= N), so a check or request takes
//   longer as N grows; a granted or safe result then emits its sequence
//   entries one by one, each as the output register frees up.
//   Reset clears the tables (row valid bits), available counts and the
//   output register; active counts return to one.
//   While the receiver stalls, the output word holds and emission waits.
// ----------------------------------------------------------------------------
`default_nettype none

module bankers_resource_allocator #(
  parameter int PROCESSES   = 16,
  parameter int RESOURCES   = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [3:0]  in_process_index,
  input  wire logic [2:0]  in_resource_index,
  input  wire logic [15:0] in_amount,
  input  wire logic        in_last_element,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic             out_released,
  output logic             out_sequence_valid,
  output logic [3:0]       out_sequence_process,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_data
);

  bra_pkg::dp_cmd_t cmd;
  bra_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  bra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bra_datapath #(
    .PROCESSES   (PROCESSES),
    .RESOURCES   (RESOURCES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_opcode            (in_opcode),
    .in_process_index     (in_process_index),
    .in_resource_index    (in_resource_index),
    .in_amount            (in_amount),
    .in_last_element      (in_last_element),
    .cfg_valid            (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_released         (out_released),
    .out_sequence_valid   (out_sequence_valid),
    .out_sequence_process (out_sequence_process),
    .out_last             (out_last)
  );

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the banker's resource allocator
// Drives load, request and safety-check words through the input channel,
// predicts every result word with a behavioral copy of the allocator tables,
// and checks the result channel field by field under random idling and stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NPROC = 16;
  localparam int NRES = 8;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [2:0] opcode;
    logic [3:0] process_index;
    logic [2:0] resource_index;
    logic [15:0] amount;
    logic last_element;
  } alloc_word_t;

  typedef struct {
    logic [2:0] status;
    logic released;
    logic sequence_valid;
    logic [3:0] sequence_process;
    logic last;
  } result_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_opcode = '0;
  logic [3:0] in_process_index = '0;
  logic [2:0] in_resource_index = '0;
  logic [15:0] in_amount = '0;
  logic in_last_element = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic out_released;
  logic out_sequence_valid;
  logic [3:0] out_sequence_process;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [4:0] cfg_data = '0;

  bankers_resource_allocator i_dut (.*);

  // allocator mirror
  logic [15:0] claim_tbl[NPROC][NRES];
  logic [15:0] alloc_tbl[NPROC][NRES];
  logic [15:0] need_tbl[NPROC][NRES];
  logic [15:0] avail_units[NRES];
  logic [15:0] req_units[NRES];
  logic [3:0] safe_seq[NPROC];
  logic [4:0] proc_reg = 5'd1;
  logic [3:0] res_reg = 4'd1;

  alloc_word_t pending_words[$];
  alloc_word_t offered_word;
  result_word_t expected_results[$];
  int errors = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  logic [7:0] req_written = '0;

  function automatic int proc_count();
    if (proc_reg < 1) return 1;
    if (proc_reg > NPROC) return NPROC;
    return proc_reg;
  endfunction

  function automatic int res_count();
    if (res_reg < 1) return 1;
    if (res_reg > NRES) return NRES;
    return res_reg;
  endfunction

  function automatic logic [15:0] sat_sum(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = a + b;
    return s[16] ? 16'hffff : s[15:0];
  endfunction

  // run the safety scan; fills safe_seq on success
  function automatic bit is_safe_state();
    logic [15:0] work[NRES];
    logic [NPROC-1:0] done;
    int np, nr, cnt, prev;
    bit fits;
    np = proc_count();
    nr = res_count();
    cnt = 0;
    done = '0;
    for (int j = 0; j < nr; j++) work[j] = avail_units[j];
    while (cnt < np) begin
      prev = cnt;
      for (int i = 0; i < np; i++) begin
        if (done[i]) continue;
        fits = 1;
        for (int j = 0; j < nr; j++) if (need_tbl[i][j] > work[j]) fits = 0;
        if (fits) begin
          done[i] = 1'b1;
          for (int j = 0; j < nr; j++) work[j] = sat_sum(work[j], alloc_tbl[i][j]);
          safe_seq[cnt] = 4'(i);
          cnt++;
        end
      end
      if (cnt == prev) return 0;
    end
    return 1;
  endfunction

  function automatic void push_single(logic [2:0] st, logic rel);
    expected_results.push_back('{st, rel, 1'b0, 4'd0, 1'b1});
  endfunction

  function automatic void push_sequence(logic [2:0] st, logic rel);
    int np;
    np = proc_count();
    for (int k = 0; k < np; k++)
      expected_results.push_back('{st, rel, 1'b1, safe_seq[k], k == np - 1});
  endfunction

  // apply one accepted word to the mirror and queue its results
  function automatic void predict_word(alloc_word_t w);
    int np, nr, p, r;
    bit p_ok, r_ok, safe, rel;
    np = proc_count();
    nr = res_count();
    p = w.process_index;
    r = w.resource_index;
    p_ok = p < np;
    r_ok = r < nr;
    case (w.opcode)
      bra_pkg::OP_SET_MAX: begin
        if (!p_ok || !r_ok) begin
          push_single(bra_pkg::ST_BAD_ENTRY, 0);
          return;
        end
        claim_tbl[p][r] = w.amount;
        push_single(bra_pkg::ST_STORED, 0);
      end
      bra_pkg::OP_SET_ALLOC: begin
        if (!p_ok || !r_ok || w.amount > claim_tbl[p][r]) begin
          push_single(bra_pkg::ST_BAD_ENTRY, 0);
          return;
        end
        alloc_tbl[p][r] = w.amount;
        need_tbl[p][r] = claim_tbl[p][r] - w.amount;
        push_single(bra_pkg::ST_STORED, 0);
      end
      bra_pkg::OP_SET_AVAIL: begin
        if (!r_ok) begin
          push_single(bra_pkg::ST_BAD_ENTRY, 0);
          return;
        end
        avail_units[r] = w.amount;
        push_single(bra_pkg::ST_STORED, 0);
      end
      bra_pkg::OP_REQUEST: begin
        if (r_ok) req_units[r] = w.amount;
        if (!w.last_element) begin
          push_single(r_ok ? bra_pkg::ST_STORED : bra_pkg::ST_BAD_ENTRY, 0);
          return;
        end
        if (!p_ok) begin
          push_single(bra_pkg::ST_BAD_ENTRY, 0);
          return;
        end
        for (int j = 0; j < nr; j++) begin
          if (req_units[j] > need_tbl[p][j]) begin
            push_single(bra_pkg::ST_OVER_NEED, 0);
            return;
          end
          if (req_units[j] > avail_units[j]) begin
            push_single(bra_pkg::ST_OVER_AVAIL, 0);
            return;
          end
        end
        for (int j = 0; j < nr; j++) begin
          avail_units[j] -= req_units[j];
          alloc_tbl[p][j] += req_units[j];
          need_tbl[p][j] -= req_units[j];
        end
        safe = is_safe_state();
        if (!safe) begin
          for (int j = 0; j < nr; j++) begin
            avail_units[j] += req_units[j];
            alloc_tbl[p][j] -= req_units[j];
            need_tbl[p][j] += req_units[j];
          end
        end
        rel = 1;
        for (int j = 0; j < nr; j++) if (need_tbl[p][j] != 0) rel = 0;
        if (rel) begin
          for (int j = 0; j < nr; j++) begin
            avail_units[j] = sat_sum(avail_units[j], alloc_tbl[p][j]);
            alloc_tbl[p][j] = '0;
            need_tbl[p][j] = '0;
          end
        end
        if (safe) push_sequence(bra_pkg::ST_GRANTED, rel);
        else push_single(bra_pkg::ST_DENIED, rel);
      end
      bra_pkg::OP_CHECK: begin
        if (is_safe_state()) push_sequence(bra_pkg::ST_SAFE, 0);
        else push_single(bra_pkg::ST_UNSAFE, 0);
      end
      default: push_single(bra_pkg::ST_BAD_ENTRY, 0);
    endcase
  endfunction

  // stimulus builders
  function automatic void add_word(int op, int p, int r, int amt, int lst);
    alloc_word_t w;
    w = '{op[2:0], p[3:0], r[2:0], amt[15:0], lst[0]};
    // never decide on a buffer entry that was never written
    if (w.opcode == bra_pkg::OP_REQUEST && w.last_element
        && (req_written | ~((8'd1 << res_count()) - 1)) != 8'hff
        && !(w.resource_index < res_count()
             && (req_written | (8'd1 << w.resource_index)
                 | ~((8'd1 << res_count()) - 1)) == 8'hff))
      w.last_element = 1'b0;
    if (w.opcode == bra_pkg::OP_REQUEST && w.resource_index < res_count())
      req_written[w.resource_index] = 1'b1;
    pending_words.push_back(w);
  endfunction

  function automatic int rand_amount();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 6);
  endfunction

  function automatic int rand_proc();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                       : $urandom_range(0, proc_count() - 1);
  endfunction

  function automatic int rand_res();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7)
                                       : $urandom_range(0, res_count() - 1);
  endfunction

  // well-formed rounds with random content, plus some noise
  function automatic void add_random_words(int count);
    int target, p, op;
    target = pending_words.size() + count;
    while (pending_words.size() < target) begin
      op = $urandom_range(0, 9);
      if (op < 3) begin
        add_word(op, rand_proc(), rand_res(), rand_amount(), $urandom_range(0, 1));
      end else if (op < 7) begin
        p = rand_proc();
        for (int j = 0; j < res_count(); j++)
          add_word(bra_pkg::OP_REQUEST, p, j, $urandom_range(0, 2), j == res_count() - 1);
      end else if (op < 8) begin
        add_word(bra_pkg::OP_CHECK, rand_proc(), rand_res(), rand_amount(),
                 $urandom_range(0, 1));
      end else begin
        add_word($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 7),
                 $urandom_range(0, 65535), $urandom_range(0, 1));
      end
    end
  endfunction

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // input driver: present words from the pending queue, predict on accept
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_word(offered_word);
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && $urandom_range(0, 99) >= in_idle_pct) begin
          offered_word = pending_words.pop_front();
          in_valid <= 1'b1;
          in_opcode <= offered_word.opcode;
          in_process_index <= offered_word.process_index;
          in_resource_index <= offered_word.resource_index;
          in_amount <= offered_word.amount;
          in_last_element <= offered_word.last_element;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result stall: random, or a long hold when asked
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req != 0) begin
      hold_req <= 0;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(0, 99) < out_idle_pct;
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word status=%0d", out_status);
        errors++;
      end else begin
        exp_w = expected_results.pop_front();
        if (out_status !== exp_w.status) begin
          $error("status: expected %0d, got %0d", exp_w.status, out_status);
          errors++;
        end
        if (out_released !== exp_w.released) begin
          $error("released: expected %0d, got %0d", exp_w.released, out_released);
          errors++;
        end
        if (out_sequence_valid !== exp_w.sequence_valid) begin
          $error("sequence_valid: expected %0d, got %0d", exp_w.sequence_valid,
                 out_sequence_valid);
          errors++;
        end
        if (out_sequence_process !== exp_w.sequence_process) begin
          $error("sequence_process: expected %0d, got %0d", exp_w.sequence_process,
                 out_sequence_process);
          errors++;
        end
        if (out_last !== exp_w.last) begin
          $error("last: expected %0d, got %0d", exp_w.last, out_last);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // write one configuration register while idle
  task automatic write_cfg(logic idx, logic [4:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == bra_pkg::CFG_ACTIVE_PROCESSES) proc_reg = value;
    else res_reg = value[3:0];
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic run_phase(int np, int nr, int in_pct, int out_pct, int count);
    write_cfg(bra_pkg::CFG_ACTIVE_PROCESSES, 5'(np));
    write_cfg(bra_pkg::CFG_ACTIVE_RESOURCES, 5'(nr));
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    add_random_words(count);
    drain();
  endtask

  initial begin
    for (int i = 0; i < NPROC; i++)
      for (int j = 0; j < NRES; j++) begin
        claim_tbl[i][j] = '0;
        alloc_tbl[i][j] = '0;
        need_tbl[i][j] = '0;
      end
    for (int j = 0; j < NRES; j++) begin
      avail_units[j] = '0;
      req_units[j] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (5) @(posedge clk);

    // directed: extremes, every opcode, bad entries, refusals
    write_cfg(bra_pkg::CFG_ACTIVE_PROCESSES, 5'd16);
    write_cfg(bra_pkg::CFG_ACTIVE_RESOURCES, 5'd8);
    add_word(bra_pkg::OP_SET_AVAIL, 0, 0, 65535, 0);
    add_word(bra_pkg::OP_SET_AVAIL, 0, 7, 0, 1);
    add_word(bra_pkg::OP_SET_MAX, 15, 7, 65535, 0);
    add_word(bra_pkg::OP_SET_ALLOC, 15, 7, 65535, 0);
    add_word(bra_pkg::OP_SET_ALLOC, 0, 0, 5, 0);
    add_word(bra_pkg::OP_SET_MAX, 1, 0, 3, 0);
    add_word(bra_pkg::OP_SET_ALLOC, 1, 0, 1, 0);
    add_word(bra_pkg::OP_CHECK, 0, 0, 0, 0);
    for (int j = 0; j < NRES; j++)
      add_word(bra_pkg::OP_REQUEST, 1, j, j == 0 ? 2 : 0, j == 7);
    for (int j = 0; j < NRES; j++)
      add_word(bra_pkg::OP_REQUEST, 2, j, j == 0 ? 1 : 0, j == 7);
    add_word(bra_pkg::OP_REQUEST, 3, 7, 1, 1);
    add_word(5, 0, 0, 0, 0);
    add_word(7, 15, 7, 65535, 1);
    drain();

    // random phases over several register settings
    run_phase(16, 8, 0, 0, 20);
    run_phase(1, 1, 79, 0, 25);
    hold_req = 1;
    in_idle_pct = 0;
    add_random_words(15);
    drain();
    run_phase(4, 3, 0, 79, 25);
    run_phase(31, 15, 37, 37, 25);
    run_phase(0, 0, 0, 0, 10);
    run_phase(2, 8, 0, 0, 15);

    if (errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ bankers_resource_allocator.f @@
src/bra_pkg.sv
src/bra_ctrl.sv
src/bra_datapath.sv
src/bankers_resource_allocator.sv
verif/testbench.sv
